### sv/rrfp_pkg.sv
package rrfp_pkg;

    // Fixed frame layout: header, type, command, two length bytes, checksum, end
    localparam int FRAME_OVERHEAD = 7;

    // Register reset values
    localparam logic [7:0] HEADER_RESET  = 8'd187;
    localparam logic [7:0] END_RESET     = 8'd126;
    localparam logic [7:0] TYPE_RESET    = 8'd0;
    localparam logic [7:0] COMMAND_RESET = 8'd0;

    typedef enum logic [2:0] {
        VERDICT_SKIPPED  = 3'd0,
        VERDICT_ACCEPTED = 3'd1,
        VERDICT_GOOD     = 3'd2,
        VERDICT_OVERFLOW = 3'd3,
        VERDICT_BAD_END  = 3'd4,
        VERDICT_CHECKSUM = 3'd5
    } verdict_t;

    typedef enum logic [1:0] {
        REG_HEADER  = 2'd0,
        REG_END     = 2'd1,
        REG_TYPE    = 2'd2,
        REG_COMMAND = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] end_byte;
        logic [7:0] wanted_type;
        logic [7:0] wanted_command;
    } cfg_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [7:0]  byte_position;
        logic [7:0]  byte_echo;
        logic [7:0]  frame_type;
        logic [7:0]  frame_command;
        logic [15:0] payload_size;
        logic        type_command_match;
    } result_t;

endpackage

### sv/rrfp_cfg_regs.sv
module rrfp_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output rrfp_pkg::cfg_t       cfg
);
    import rrfp_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       write_en;

    assign index    = reg_index_t'(paddr[3:2]);
    assign write_en = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign cfg      = cfg_reg;

    // Write the addressed register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_byte    <= HEADER_RESET;
            cfg_reg.end_byte       <= END_RESET;
            cfg_reg.wanted_type    <= TYPE_RESET;
            cfg_reg.wanted_command <= COMMAND_RESET;
        end
        else if (write_en)
        begin
            unique case (index)
                REG_HEADER:  cfg_reg.header_byte    <= pwdata[7:0];
                REG_END:     cfg_reg.end_byte       <= pwdata[7:0];
                REG_TYPE:    cfg_reg.wanted_type    <= pwdata[7:0];
                REG_COMMAND: cfg_reg.wanted_command <= pwdata[7:0];
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (index)
            REG_HEADER:  prdata = 32'(cfg_reg.header_byte);
            REG_END:     prdata = 32'(cfg_reg.end_byte);
            REG_TYPE:    prdata = 32'(cfg_reg.wanted_type);
            REG_COMMAND: prdata = 32'(cfg_reg.wanted_command);
        endcase
    end

endmodule

### sv/rrfp_core.sv
module rrfp_core #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    input  rrfp_pkg::cfg_t       cfg,
    output rrfp_pkg::result_t    result
);
    import rrfp_pkg::*;

    // Position and total length both fit the buffer size itself
    localparam int PW = $clog2(BUFFER_BYTES + 1);
    localparam int LW = PW + 1;

    logic [PW-1:0] pos_reg,     pos_next;
    logic [PW-1:0] total_reg,   total_next;
    logic [7:0]    sum_reg,     sum_next;
    logic [7:0]    type_reg,    type_next;
    logic [7:0]    command_reg, command_next;
    logic [7:0]    len_hi_reg,  len_hi_next;

    logic [16:0]   full_total;
    logic          overflow;
    logic [LW-1:0] pos_ext;
    logic [LW-1:0] total_ext;
    logic          in_body;
    logic          at_checksum;
    verdict_t      verdict;
    logic          match;
    logic [15:0]   plen;

    assign full_total = 17'(FRAME_OVERHEAD) + {1'b0, len_hi_reg, rx_byte};
    assign overflow   = full_total > 17'(BUFFER_BYTES);
    assign pos_ext    = LW'(pos_reg);
    assign total_ext  = LW'(total_reg);
    assign in_body    = (pos_reg <= PW'(4)) || (pos_ext + LW'(3) <= total_ext);
    assign at_checksum = (pos_ext + LW'(2) == total_ext);

    // Decode one byte against the current frame position
    always_comb
    begin
        pos_next     = pos_reg;
        total_next   = total_reg;
        sum_next     = sum_reg;
        type_next    = type_reg;
        command_next = command_reg;
        len_hi_next  = len_hi_reg;
        verdict      = VERDICT_ACCEPTED;
        match        = 1'b0;
        plen         = 16'd0;

        if (pos_reg == '0)
        begin
            if (rx_byte != cfg.header_byte)
                verdict = VERDICT_SKIPPED;
            else
                pos_next = PW'(1);
        end
        else
        begin
            // Capture header fields
            if (pos_reg == PW'(1))
                type_next = rx_byte;
            if (pos_reg == PW'(2))
                command_next = rx_byte;
            if (pos_reg == PW'(3))
                len_hi_next = rx_byte;
            if (pos_reg == PW'(4))
            begin
                plen = {len_hi_reg, rx_byte};
                if (overflow)
                    verdict = VERDICT_OVERFLOW;
                else
                    total_next = PW'(full_total);
            end
            else if (pos_reg > PW'(4))
            begin
                plen = 16'(total_reg) - 16'(FRAME_OVERHEAD);
            end

            // Accumulate, strip the checksum, then judge the end byte
            if (verdict == VERDICT_ACCEPTED)
            begin
                priority if (in_body)
                    sum_next = sum_reg + rx_byte;
                else if (at_checksum)
                    sum_next = sum_reg - rx_byte;
                else
                begin
                    if (rx_byte != cfg.end_byte)
                        verdict = VERDICT_BAD_END;
                    else if (sum_reg != 8'd0)
                        verdict = VERDICT_CHECKSUM;
                    else
                    begin
                        verdict = VERDICT_GOOD;
                        match   = (type_reg == cfg.wanted_type) &&
                                  (command_reg == cfg.wanted_command);
                    end
                end
                pos_next = pos_reg + PW'(1);
            end
        end

        // Drop back to idle after any final verdict
        if (verdict != VERDICT_SKIPPED && verdict != VERDICT_ACCEPTED)
        begin
            pos_next     = '0;
            total_next   = '0;
            sum_next     = 8'd0;
            type_next    = 8'd0;
            command_next = 8'd0;
            len_hi_next  = 8'd0;
        end
    end

    // Shape the result for this byte
    always_comb
    begin
        result.verdict            = verdict;
        result.byte_position      = (verdict == VERDICT_SKIPPED) ? 8'd0 : 8'(pos_reg);
        result.byte_echo          = rx_byte;
        result.frame_type         = (pos_reg == PW'(1)) ? rx_byte : type_reg;
        result.frame_command      = (pos_reg == PW'(2)) ? rx_byte : command_reg;
        result.payload_size       = plen;
        result.type_command_match = match;
    end

    // Hold frame state between bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            total_reg   <= '0;
            sum_reg     <= 8'd0;
            type_reg    <= 8'd0;
            command_reg <= 8'd0;
            len_hi_reg  <= 8'd0;
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            sum_reg     <= sum_next;
            type_reg    <= type_next;
            command_reg <= command_next;
            len_hi_reg  <= len_hi_next;
        end
    end

endmodule

### sv/rfid_reader_frame_parser_top.sv
// A byte accepted into the input register is parsed by the core into the result
// register, where out_valid rises; a blocked result register holds it back.
// Throughput: one byte per cycle while out_ready allows; the input and result registers
// each take a new request whenever the stage after them empties in the same cycle.
// Reset (rst_n low, asynchronous) empties both registers, returns the parser to
// idle and loads header 187, end 126, wanted type 0 and wanted command 0.
module rfid_reader_frame_parser_top #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  verdict,
    output logic [7:0]  byte_position,
    output logic [7:0]  byte_echo,
    output logic [7:0]  frame_type,
    output logic [7:0]  frame_command,
    output logic [15:0] payload_size,
    output logic        type_command_match
);
    import rrfp_pkg::*;

    cfg_t       cfg;
    result_t    core_result;
    result_t    out_result_reg;
    logic       out_valid_reg;
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       out_free;
    logic       advance;
    logic       accept;

    rrfp_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rrfp_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (s1_byte_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // Pipeline handshake
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign accept   = in_valid && in_ready;

    // Input register: hold the request until the parser takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_byte_reg <= rx_byte;
    end

    // Result register: hold until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= core_result;
    end

    assign out_valid          = out_valid_reg;
    assign verdict            = out_result_reg.verdict;
    assign byte_position      = out_result_reg.byte_position;
    assign byte_echo          = out_result_reg.byte_echo;
    assign frame_type         = out_result_reg.frame_type;
    assign frame_command      = out_result_reg.frame_command;
    assign payload_size       = out_result_reg.payload_size;
    assign type_command_match = out_result_reg.type_command_match;

    // A match is only reported on a good frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && type_command_match |-> out_result_reg.verdict == VERDICT_GOOD)
        else $error("match flag outside a good frame");

    // A skipped byte carries position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_result_reg.verdict == VERDICT_SKIPPED |-> byte_position == 8'd0)
        else $error("skipped byte with nonzero position");

    // A parsed byte always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("parsed byte lost");

    // Input stalls only when both stages are full and the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled with room in the pipeline");

endmodule

### verif/tb_rfid_reader_frame_parser_top.sv
module tb_rfid_reader_frame_parser_top;
    import rrfp_pkg::*;

    localparam int BUFFER_BYTES = 256;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_QUOTA  = 250;

    typedef enum {
        SHAPE_GOOD,
        SHAPE_BAD_SUM,
        SHAPE_BAD_END,
        SHAPE_TOO_LONG,
        SHAPE_CUT,
        SHAPE_NOISE
    } frame_shape_t;

    // Frame deframer predictor and store of expected per-byte results
    class frame_scoreboard;
        cfg_t        cfg;
        logic [8:0]  position;
        logic [8:0]  total_len;
        logic [7:0]  sum;
        logic [7:0]  type_q;
        logic [7:0]  cmd_q;
        logic [7:0]  len_hi;
        result_t     expected_q[$];
        int unsigned framed_count;
        int unsigned errors;

        function new();
            cfg = '{HEADER_RESET, END_RESET, TYPE_RESET, COMMAND_RESET};
            clear_frame();
            framed_count = 0;
            errors = 0;
        endfunction

        function void clear_frame();
            position  = '0;
            total_len = '0;
            sum       = '0;
            type_q    = '0;
            cmd_q     = '0;
            len_hi    = '0;
        endfunction

        function void write_reg(reg_index_t idx, logic [7:0] value);
            case (idx)
                REG_HEADER:  cfg.header_byte    = value;
                REG_END:     cfg.end_byte       = value;
                REG_TYPE:    cfg.wanted_type    = value;
                REG_COMMAND: cfg.wanted_command = value;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Advance the deframer by one accepted byte and queue its result
        function void note_byte(logic [7:0] rx);
            result_t     r;
            verdict_t    v;
            logic [8:0]  pos;
            logic [16:0] frame_len;
            r = '0;
            v = VERDICT_ACCEPTED;
            pos = position;
            frame_len = {8'd0, total_len};
            if (pos == 0)
            begin
                if (rx != cfg.header_byte)
                    v = VERDICT_SKIPPED;
                else
                    position = 9'd1;
            end
            else
            begin
                case (pos)
                    9'd1: type_q = rx;
                    9'd2: cmd_q  = rx;
                    9'd3: len_hi = rx;
                    9'd4:
                    begin
                        frame_len = 17'(FRAME_OVERHEAD) + {1'b0, len_hi, rx};
                        if (frame_len > BUFFER_BYTES)
                            v = VERDICT_OVERFLOW;
                        else
                            total_len = frame_len[8:0];
                    end
                    default: ;
                endcase
                if (pos >= 4)
                    r.payload_size = 16'(frame_len - FRAME_OVERHEAD);
                if (v == VERDICT_ACCEPTED)
                begin
                    // Sum type through payload, take the checksum off, judge the end byte
                    if (pos <= 4 || pos + 3 <= frame_len)
                        sum = sum + rx;
                    else if (pos + 2 == frame_len)
                        sum = sum - rx;
                    else if (rx != cfg.end_byte)
                        v = VERDICT_BAD_END;
                    else if (sum != 0)
                        v = VERDICT_CHECKSUM;
                    else
                    begin
                        v = VERDICT_GOOD;
                        r.type_command_match = (type_q == cfg.wanted_type) &&
                                               (cmd_q == cfg.wanted_command);
                    end
                    position = pos + 9'd1;
                end
            end
            r.verdict       = v;
            r.byte_position = (v == VERDICT_SKIPPED) ? 8'd0 : pos[7:0];
            r.byte_echo     = rx;
            r.frame_type    = type_q;
            r.frame_command = cmd_q;
            expected_q.push_back(r);
            if (v != VERDICT_SKIPPED)
                framed_count++;
            if (v >= VERDICT_GOOD)
                clear_frame();
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with no expectation waiting, byte_echo %0d", got.byte_echo);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            check_field("verdict", want.verdict, got.verdict);
            check_field("byte_position", want.byte_position, got.byte_position);
            check_field("byte_echo", want.byte_echo, got.byte_echo);
            check_field("frame_type", want.frame_type, got.frame_type);
            check_field("frame_command", want.frame_command, got.frame_command);
            check_field("payload_size", want.payload_size, got.payload_size);
            check_field("type_command_match", want.type_command_match,
                        got.type_command_match);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  verdict;
    logic [7:0]  byte_position;
    logic [7:0]  byte_echo;
    logic [7:0]  frame_type;
    logic [7:0]  frame_command;
    logic [15:0] payload_size;
    logic        type_command_match;

    result_t         seen_result;
    frame_scoreboard sb;
    int unsigned     send_gap = 6;
    int unsigned     recv_stall = 77;
    int unsigned     cycles = 0;

    rfid_reader_frame_parser_top #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .verdict(verdict),
        .byte_position(byte_position),
        .byte_echo(byte_echo),
        .frame_type(frame_type),
        .frame_command(frame_command),
        .payload_size(payload_size),
        .type_command_match(type_command_match)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    assign seen_result = {verdict, byte_position, byte_echo, frame_type, frame_command,
                          payload_size, type_command_match};

    // Stall the result side at random
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall);

    // Note accepted requests and check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_byte(rx_byte);
            if (out_valid && out_ready)
                sb.check_result(seen_result);
        end
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Hold one byte request until it is taken; leaves valid high
    task automatic send_byte(logic [7:0] value);
        while ($urandom_range(99) < send_gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Write one register, then read it back
    task automatic write_register(reg_index_t idx, logic [7:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        sb.write_reg(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback != {24'd0, value})
        begin
            $error("prdata: expected %0d, got %0d", value, readback);
            sb.errors++;
        end
    endtask

    task automatic load_settings(logic [7:0] hdr, logic [7:0] tail, logic [7:0] typ,
                                 logic [7:0] cmd);
        write_register(REG_HEADER, hdr);
        write_register(REG_END, tail);
        write_register(REG_TYPE, typ);
        write_register(REG_COMMAND, cmd);
    endtask

    // Wait until every expected result is back before moving on
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // Send one frame of the given shape under the current settings
    task automatic send_frame(frame_shape_t shape, logic [15:0] len, logic [7:0] typ,
                              logic [7:0] cmd);
        logic [7:0]  csum;
        logic [7:0]  data;
        int unsigned keep;
        csum = typ + cmd + len[15:8] + len[7:0];
        send_byte(sb.cfg.header_byte);
        send_byte(typ);
        send_byte(cmd);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (shape == SHAPE_TOO_LONG)
            return;
        keep = (shape == SHAPE_CUT) ? $urandom_range(len) : len;
        for (int i = 0; i < keep; i++)
        begin
            data = 8'($urandom);
            csum = csum + data;
            send_byte(data);
        end
        if (shape == SHAPE_CUT)
            return;
        if (shape == SHAPE_BAD_SUM)
            csum = csum + 8'($urandom_range(1, 255));
        send_byte(csum);
        if (shape == SHAPE_BAD_END)
            send_byte(sb.cfg.end_byte ^ 8'($urandom_range(1, 255)));
        else
            send_byte(sb.cfg.end_byte);
    endtask

    // Mostly short payloads, now and then a longer one or the largest that fits
    function automatic logic [15:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return 16'($urandom_range(8));
        if (roll < 93)
            return 16'($urandom_range(9, BUFFER_BYTES - FRAME_OVERHEAD));
        return 16'(BUFFER_BYTES - FRAME_OVERHEAD);
    endfunction

    task automatic random_frame();
        int unsigned   roll;
        frame_shape_t  shape;
        logic [15:0]   len;
        logic [7:0]    typ;
        logic [7:0]    cmd;
        roll = $urandom_range(99);
        if (roll < 55)
            shape = SHAPE_GOOD;
        else if (roll < 65)
            shape = SHAPE_BAD_SUM;
        else if (roll < 75)
            shape = SHAPE_BAD_END;
        else if (roll < 83)
            shape = SHAPE_TOO_LONG;
        else if (roll < 93)
            shape = SHAPE_CUT;
        else
            shape = SHAPE_NOISE;
        if (shape == SHAPE_NOISE)
        begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            return;
        end
        // Half the frames carry the wanted type, three in four the wanted command
        typ = ($urandom_range(3) < 2) ? 8'($urandom) : sb.cfg.wanted_type;
        cmd = ($urandom_range(3) == 0) ? 8'($urandom) : sb.cfg.wanted_command;
        if (shape == SHAPE_TOO_LONG)
        begin
            roll = $urandom_range(99);
            if (roll < 40)
                len = 16'(BUFFER_BYTES - FRAME_OVERHEAD + 1);
            else if (roll < 50)
                len = 16'hFFFF;
            else
                len = 16'($urandom_range(BUFFER_BYTES - FRAME_OVERHEAD + 2, 65535));
        end
        else
            len = pick_length();
        send_frame(shape, len, typ, cmd);
    endtask

    initial
    begin
        int unsigned goal;
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed bytes under the reset settings
        send_byte(8'h00);
        send_frame(SHAPE_GOOD, 16'd0, 8'h00, 8'h00);
        send_frame(SHAPE_TOO_LONG, 16'hFFFF, 8'hFF, 8'hFF);
        send_frame(SHAPE_BAD_END, 16'd0, 8'h12, 8'h34);
        send_frame(SHAPE_BAD_SUM, 16'd0, 8'h56, 8'h78);
        in_valid <= 1'b0;
        drain();

        // Random phases: extreme settings first, then random ones
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    send_gap   = 6;
                    recv_stall = 77;
                end
                1:
                begin
                    send_gap   = 77;
                    recv_stall = 6;
                end
                default:
                begin
                    send_gap   = 0;
                    recv_stall = 0;
                end
            endcase
            if (phase == 0)
                load_settings(8'h00, 8'hFF, 8'hFF, 8'h00);
            else if (phase == 1)
                load_settings(8'hFF, 8'h00, 8'h00, 8'hFF);
            else
                load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            goal = sb.framed_count + PHASE_QUOTA;
            while (sb.framed_count < goal)
                random_frame();
            in_valid <= 1'b0;
            drain();
        end

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
sv/rrfp_pkg.sv
sv/rrfp_cfg_regs.sv
sv/rrfp_core.sv
sv/rfid_reader_frame_parser_top.sv
verif/tb_rfid_reader_frame_parser_top.sv
